/* rtl/spg_pkg.sv */
package spg_pkg;

  // Sponge state geometry.
  localparam int STATE_W    = 136;
  localparam int PERM_MOD   = 135;
  localparam int PERM_MUL   = 34;
  localparam int NIBBLES    = STATE_W / 4;
  localparam int BYTE_W     = 8;

  // Round constant LFSR.
  localparam int LFSR_W                 = 7;
  localparam logic [LFSR_W-1:0] LFSR_INIT = 7'h7A;

  // Counter widths follow the parameter ranges of the block.
  localparam int RND_CNT_W = 7;
  localparam int SQZ_CNT_W = 5;

  // Padding byte for the end of a message.
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ABSORB = 5'b00010,
    ST_PAD    = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_SQZ    = 5'b10000
  } spg_state_t;

  // Result item handed to the output register.
  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } spg_item_t;

  // Spongent S-box.
  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hE;
      4'h1: y = 4'hD;
      4'h2: y = 4'hB;
      4'h3: y = 4'h0;
      4'h4: y = 4'h2;
      4'h5: y = 4'h1;
      4'h6: y = 4'h4;
      4'h7: y = 4'hF;
      4'h8: y = 4'h7;
      4'h9: y = 4'hA;
      4'hA: y = 4'h8;
      4'hB: y = 4'h5;
      4'hC: y = 4'h9;
      4'hD: y = 4'hC;
      4'hE: y = 4'h3;
      default: y = 4'h6;
    endcase
    return y;
  endfunction

  // Next value of the round constant LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    return {s[LFSR_W-2:0], s[6] ^ s[5]};
  endfunction

endpackage

/* rtl/spongent128_sponge_hash_unit.sv */
// Spongent-128/128/8 sponge hash, one permutation round per clock cycle.
// A message byte item keeps in_tready low while its permutation runs, so a new item is
// taken only after the last one is absorbed. An end-of-message item adds the padding
// permutation, then each digest byte is emitted with a squeeze permutation between bytes,
// waiting on receiver stalls; in_tready stays low until the last digest byte is loaded.
// Synchronous active-low reset clears the state to zero and empties the output.
module spongent128_sponge_hash_unit import spg_pkg::*; #(
  parameter int ROUNDS       = 70,
  parameter int DIGEST_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // data_value[7:0]
  input  logic              in_tuser,   // has_data
  input  logic              in_tlast,   // end_of_message
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // digest_value[7:0]
  output logic              out_tlast   // last_of_digest
);

  localparam logic [RND_CNT_W-1:0] RND_LAST = RND_CNT_W'(ROUNDS - 1);
  localparam logic [SQZ_CNT_W-1:0] SQZ_LAST = SQZ_CNT_W'(DIGEST_BYTES - 1);

  spg_state_t          fsm_r, fsm_nxt;
  logic [STATE_W-1:0]  sponge_r, sponge_nxt;
  logic [LFSR_W-1:0]   rc_r, rc_nxt;
  logic [RND_CNT_W-1:0] rnd_r, rnd_nxt;
  logic [SQZ_CNT_W-1:0] sqz_r, sqz_nxt;
  logic                end_r, end_nxt;
  logic [STATE_W-1:0]  round_out;
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  spg_item_t           out_item;

  spg_round u_round (
    .state_i (sponge_r),
    .rc_i    (rc_r),
    .state_o (round_out)
  );

  spg_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (out_load),
    .item_i     (out_item),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign in_tready = (fsm_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign out_item.data = sponge_r[BYTE_W-1:0];
  assign out_item.last = (sqz_r == SQZ_LAST);
  assign out_load      = (fsm_r == ST_EMIT) && out_free;

  // Sequencer around the shared round unit.
  always_comb begin
    fsm_nxt    = fsm_r;
    sponge_nxt = sponge_r;
    rc_nxt     = rc_r;
    rnd_nxt    = rnd_r;
    sqz_nxt    = sqz_r;
    end_nxt    = end_r;
    unique case (fsm_r)
      ST_IDLE: begin
        rc_nxt  = LFSR_INIT;
        rnd_nxt = '0;
        sqz_nxt = '0;
        if (in_acc) begin
          end_nxt = in_tlast;
          if (in_tuser) begin
            sponge_nxt[BYTE_W-1:0] = sponge_r[BYTE_W-1:0] ^ in_tdata;
            fsm_nxt = ST_ABSORB;
          end else if (in_tlast) begin
            sponge_nxt[BYTE_W-1:0] = sponge_r[BYTE_W-1:0] ^ PAD_BYTE;
            fsm_nxt = ST_PAD;
          end
        end
      end
      ST_ABSORB, ST_PAD, ST_SQZ: begin
        sponge_nxt = round_out;
        rc_nxt     = lfsr_next(rc_r);
        rnd_nxt    = rnd_r + 1'b1;
        if (rnd_r == RND_LAST) begin
          rc_nxt  = LFSR_INIT;
          rnd_nxt = '0;
          if (fsm_r == ST_ABSORB) begin
            // Pad right after the byte's permutation when the message ends.
            if (end_r) begin
              sponge_nxt[BYTE_W-1:0] = round_out[BYTE_W-1:0] ^ PAD_BYTE;
              fsm_nxt = ST_PAD;
            end else begin
              fsm_nxt = ST_IDLE;
            end
          end else begin
            fsm_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (sqz_r == SQZ_LAST) begin
            sponge_nxt = '0;
            sqz_nxt    = '0;
            fsm_nxt    = ST_IDLE;
          end else begin
            sqz_nxt = sqz_r + 1'b1;
            fsm_nxt = ST_SQZ;
          end
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= ST_IDLE;
      sponge_r <= '0;
      rc_r     <= LFSR_INIT;
      rnd_r    <= '0;
      sqz_r    <= '0;
      end_r    <= 1'b0;
    end else begin
      fsm_r    <= fsm_nxt;
      sponge_r <= sponge_nxt;
      rc_r     <= rc_nxt;
      rnd_r    <= rnd_nxt;
      sqz_r    <= sqz_nxt;
      end_r    <= end_nxt;
    end
  end

endmodule

/* rtl/spg_round.sv */
module spg_round import spg_pkg::*; (
  input  logic [STATE_W-1:0] state_i,
  input  logic [LFSR_W-1:0]  rc_i,
  output logic [STATE_W-1:0] state_o
);

  logic [STATE_W-1:0] with_rc;
  logic [STATE_W-1:0] subbed;

  // Add the round constant to byte 0 and its bit reversal to byte 16.
  always_comb begin
    with_rc = state_i;
    with_rc[LFSR_W-1:0] = state_i[LFSR_W-1:0] ^ rc_i;
    for (int k = 0; k < LFSR_W; k++) begin
      with_rc[STATE_W-1-k] = state_i[STATE_W-1-k] ^ rc_i[k];
    end
  end

  // S-box layer over all nibbles.
  always_comb begin
    for (int n = 0; n < NIBBLES; n++) begin
      subbed[4*n +: 4] = sbox(with_rc[4*n +: 4]);
    end
  end

  // Bit permutation: bit i moves to (i * 34) mod 135, the top bit stays.
  for (genvar i = 0; i < PERM_MOD; i++) begin : g_perm
    localparam int DST = (i * PERM_MUL) % PERM_MOD;
    assign state_o[DST] = subbed[i];
  end
  assign state_o[STATE_W-1] = subbed[STATE_W-1];

endmodule

/* rtl/spg_out_reg.sv */
module spg_out_reg import spg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  spg_item_t         item_i,
  output logic              free_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic      valid_r, valid_nxt;
  spg_item_t item_r;

  // The register can take a new item when empty or being drained.
  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_i) begin
      item_r <= item_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = item_r.data;
  assign out_tlast  = item_r.last;

endmodule

/* dv/tb_spongent128_sponge_hash_unit.sv */
`timescale 1ns / 1ps

module tb_spongent128_sponge_hash_unit import spg_pkg::*; ();

  localparam int ROUNDS       = 70;
  localparam int DIGEST_BYTES = 16;
  localparam int SPONGE_W     = 136;
  localparam int PERM_SPAN    = 135;
  localparam int BIT_STRIDE   = 34;
  localparam logic [6:0] RC_SEED  = 7'h7A;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int RANDOM_ITEMS = 210;
  // Longest quiet stretch is a byte permutation plus the padding permutation
  // and a receiver stall; the limit allows many times that.
  localparam int QUIET_LIMIT  = 4000;

  // One digest byte as it appears on the result channel.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } digest_byte_t;

  // Tracks the sponge state of the block and the digest bytes still owed.
  class spongent_digest_scoreboard;
    logic [SPONGE_W-1:0] sponge;
    bit [3:0]            sbox_lut [16];
    digest_byte_t        owed_q [$];
    int                  errors;

    function new();
      sponge  = '0;
      errors  = 0;
      sbox_lut = '{4'hE, 4'hD, 4'hB, 4'h0, 4'h2, 4'h1, 4'h4, 4'hF,
                   4'h7, 4'hA, 4'h8, 4'h5, 4'h9, 4'hC, 4'h3, 4'h6};
    endfunction

    // Full permutation: constant injection, S-box layer and bit shuffle per round.
    function void permute();
      logic [SPONGE_W-1:0] mixed;
      logic [SPONGE_W-1:0] moved;
      logic [6:0]          rc;
      int                  dst;
      rc = RC_SEED;
      for (int r = 0; r < ROUNDS; r++) begin
        mixed = sponge;
        mixed[6:0] ^= rc;
        // The reversed constant lands in the top byte; its bit 7 source is zero.
        for (int k = 0; k < 7; k++) begin
          mixed[SPONGE_W-1-k] ^= rc[k];
        end
        for (int n = 0; n < SPONGE_W / 4; n++) begin
          mixed[4*n +: 4] = sbox_lut[mixed[4*n +: 4]];
        end
        moved = '0;
        for (int i = 0; i < SPONGE_W; i++) begin
          dst = (i == SPONGE_W - 1) ? i : (i * BIT_STRIDE) % PERM_SPAN;
          moved[dst] = mixed[i];
        end
        sponge = moved;
        rc = {rc[5:0], rc[6] ^ rc[5]};
      end
    endfunction

    // Absorb one accepted item and queue the digest it completes, if any.
    function void absorb_item(logic [7:0] data, logic has_byte, logic eom);
      digest_byte_t owed;
      if (has_byte) begin
        sponge[7:0] ^= data;
        permute();
      end
      if (!eom) return;
      sponge[7:0] ^= PAD_MARK;
      permute();
      for (int k = 0; k < DIGEST_BYTES; k++) begin
        owed.value = sponge[7:0];
        owed.last  = (k == DIGEST_BYTES - 1);
        owed_q.push_back(owed);
        if (k != DIGEST_BYTES - 1) permute();
      end
      sponge = '0;
    endfunction

    // Compare one accepted digest byte with the oldest one owed.
    function void check_digest_byte(logic [7:0] value, logic last);
      digest_byte_t owed;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected digest byte, actual value %h last %b", $time, value, last);
        errors++;
        return;
      end
      owed = owed_q.pop_front();
      if (value !== owed.value) begin
        $display("%0t: digest value mismatch, expected %h actual %h",
                 $time, owed.value, value);
        errors++;
      end
      if (last !== owed.last) begin
        $display("%0t: digest last flag mismatch, expected %b actual %b",
                 $time, owed.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;   // data_value[7:0]
  logic              in_tuser = 1'b0; // has_data
  logic              in_tlast = 1'b0; // end_of_message
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;       // digest_value[7:0]
  logic              out_tlast;       // last_of_digest

  spongent_digest_scoreboard digest_sb = new();
  bit steady = 1'b0;
  int sent_items = 0;
  int quiet_cycles = 0;

  spongent128_sponge_hash_unit #(
    .ROUNDS(ROUNDS),
    .DIGEST_BYTES(DIGEST_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Check every accepted digest byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      digest_sb.check_digest_byte(out_tdata, out_tlast);
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (rst_n && out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, with an optional random gap, and wait for its acceptance.
  task automatic drive_item(input logic [7:0] data, input logic has_byte, input logic eom);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 16) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has_byte;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    digest_sb.absorb_item(data, has_byte, eom);
    sent_items++;
  endtask

  // A message of random bytes, ended either on its last byte or by a separate item.
  // Idle items are scattered in as noise.
  task automatic send_message(input int len, input bit end_on_byte);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 7) == 0) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (b == len - 1));
    end
    if (!(end_on_byte && len > 0)) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, idle item, byte with end, separate end, extremes.
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'hFF, 1'b0, 1'b0);
    drive_item(8'h00, 1'b1, 1'b1);
    drive_item(8'hFF, 1'b1, 1'b0);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'h55, 1'b1, 1'b0);
    drive_item(8'hAA, 1'b1, 1'b1);
    drive_item(8'h01, 1'b1, 1'b0);
    drive_item(8'h7E, 1'b0, 1'b0);
    drive_item(8'h80, 1'b1, 1'b1);
    drive_item(8'hFF, 1'b0, 1'b1);
    drive_item(8'h00, 1'b0, 1'b1);
    drive_item(8'hFF, 1'b1, 1'b1);

    // Random messages, mostly short, with a stretch free of idling on both sides.
    while (sent_items < RANDOM_ITEMS) begin
      steady = (sent_items >= 80 && sent_items < 130);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then allow time for any stray output.
    while (digest_sb.outstanding() != 0) @(posedge clk);
    repeat (2 * ROUNDS) @(posedge clk);
    if (digest_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
